/* design/vector_character_dot_generator_assert.svh */
// assertion macros shared by the checker
`ifndef VECTOR_CHARACTER_DOT_GENERATOR_ASSERT_SVH
`define VECTOR_CHARACTER_DOT_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define VCDG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define VCDG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/vcdg_pkg.sv */
package vcdg_pkg;

    localparam int COORD_W     = 10;
    localparam int WORD_W      = 18;
    localparam int LEVEL_W     = 3;
    localparam int ACTION_W    = 3;
    localparam int SIZE_W      = 2;
    localparam int PITCH_W     = 3;
    localparam int OFFSET_W    = 5;
    localparam int COUNT_W     = 5;
    localparam int LEFT_BITS   = 17;
    localparam int RIGHT_BITS  = 18;
    localparam int ROWS_DEF    = 7;
    localparam int COLUMNS_DEF = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_USED_W  = 4 * COORD_W + LEVEL_W + 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_SIZE   = 3'd0,
        ACT_SPACE      = 3'd1,
        ACT_LOAD_LEFT  = 3'd2,
        ACT_CLEAR_PEN  = 3'd3,
        ACT_LOAD_RIGHT = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STEP_IDLE     = 3'd0,
        STEP_SET_SIZE = 3'd1,
        STEP_SPACE    = 3'd2,
        STEP_LOAD_L   = 3'd3,
        STEP_LOAD_R   = 3'd4,
        STEP_SHIFT    = 3'd5,
        STEP_CHAR_END = 3'd6,
        STEP_STATUS   = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET_SIZE,
        OP_SPACE,
        OP_LOAD_L,
        OP_LOAD_R,
        OP_SHIFT,
        OP_CHAR_END,
        OP_STATUS
    } op_t;

    typedef enum logic [1:0] {
        JMP_DISPATCH,
        JMP_GOTO,
        JMP_LOOP
    } jump_t;

    typedef struct packed {
        logic  wait_in;
        op_t   op;
        jump_t jump;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t c;
        c = '{wait_in: 1'b0, op: OP_NONE, jump: JMP_GOTO, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:     c = '{1'b1, OP_NONE,     JMP_DISPATCH, STEP_IDLE};
            STEP_SET_SIZE: c = '{1'b0, OP_SET_SIZE, JMP_GOTO,     STEP_STATUS};
            STEP_SPACE:    c = '{1'b0, OP_SPACE,    JMP_GOTO,     STEP_STATUS};
            STEP_LOAD_L:   c = '{1'b0, OP_LOAD_L,   JMP_GOTO,     STEP_SHIFT};
            STEP_LOAD_R:   c = '{1'b0, OP_LOAD_R,   JMP_GOTO,     STEP_SHIFT};
            STEP_SHIFT:    c = '{1'b0, OP_SHIFT,    JMP_LOOP,     STEP_SHIFT};
            STEP_CHAR_END: c = '{1'b0, OP_CHAR_END, JMP_GOTO,     STEP_STATUS};
            STEP_STATUS:   c = '{1'b0, OP_STATUS,   JMP_GOTO,     STEP_IDLE};
            default:       c = '{1'b1, OP_NONE,     JMP_DISPATCH, STEP_IDLE};
        endcase
        return c;
    endfunction

    function automatic step_t dispatch(input logic [ACTION_W-1:0] action);
        step_t s;
        unique case (action)
            ACT_SET_SIZE:   s = STEP_SET_SIZE;
            ACT_SPACE:      s = STEP_SPACE;
            ACT_LOAD_LEFT:  s = STEP_LOAD_L;
            ACT_LOAD_RIGHT: s = STEP_LOAD_R;
            ACT_CLEAR_PEN:  s = STEP_STATUS;
            default:        s = STEP_STATUS;
        endcase
        return s;
    endfunction

    // ones-complement fix, then move the origin to mid screen
    function automatic logic [COORD_W-1:0] screen_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] f;
        f = v[COORD_W-1] ? v + COORD_W'(1) : v;
        return {~f[COORD_W-1], f[COORD_W-2:0]};
    endfunction

endpackage

/* design/vector_character_dot_generator.sv */
// vector character dot generator
// input channel s_axis: one beat is one command; tuser carries the action,
// tdata the accumulator word, beam position, intensity and completion request
// output channel m_axis: zero or more dot beats (tuser 0) followed by one
// status beat (tuser 1, tlast 1) for every command
// a small control store steps the datapath; one command is taken only while
// the step counter sits at its idle step
// steps per command: set size and space pass through their own step and the status
// step, clear pen and unused actions go straight to the status step, and load left
// and load right pass through the load, shift, character end and status steps, one
// matrix bit per cycle through the shift step unless it holds on a stalled set bit
// each dot enters the output register from the shift step that meets a set bit
// results sit in an output register, so a new command is taken while the
// status beat still waits there
// when the receiver stalls, the shift step holds on a set bit and the status
// step holds until the output register is free
// reset clears size, pitch, gap, offsets, pen, counters and level to zero and
// parks the step counter at idle; the block takes a beat right after reset
module vector_character_dot_generator
    import vcdg_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // io_word, beam_x, beam_y, brightness_in, wants_completion, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [ACTION_W-1:0]    s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // dot_x, dot_y, dot_level, beam_x_out, beam_y_out, complete, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS + 1);

    step_t pc_reg, pc_next;
    ctrl_t ctrl;

    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [PITCH_W-1:0]  pitch_reg, pitch_next;
    logic [PITCH_W-1:0]  gap_reg, gap_next;
    logic                auto_reg, auto_next;
    logic [OFFSET_W-1:0] sub_off_reg, sub_off_next;
    logic [COORD_W-1:0]  pen_x_reg, pen_x_next;
    logic [COORD_W-1:0]  base_y_reg, base_y_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                finished_reg, finished_next;
    logic                is_load_reg, is_load_next;
    logic [COUNT_W-1:0]  bits_reg, bits_next;

    logic [WORD_W-1:0]   word_reg, word_next;
    logic [COORD_W-1:0]  bx_reg, bx_next;
    logic [COORD_W-1:0]  by_reg, by_next;
    logic [LEVEL_W-1:0]  bright_reg, bright_next;
    logic                cmpl_reg, cmpl_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [COORD_W-1:0]  out_dx_reg, out_dx_next;
    logic [COORD_W-1:0]  out_dy_reg, out_dy_next;
    logic [LEVEL_W-1:0]  out_lv_reg, out_lv_next;
    logic [COORD_W-1:0]  out_bx_reg, out_bx_next;
    logic [COORD_W-1:0]  out_by_reg, out_by_next;
    logic                out_cp_reg, out_cp_next;

    logic                in_fire;
    logic                out_busy;
    logic                top_bit;
    logic                stall;
    logic                advance;
    logic [LEVEL_W-1:0]  level_eff;
    logic [COORD_W-1:0]  dot_y_raw;
    logic [COORD_W-1:0]  space_step;
    logic [PITCH_W+1:0]  two_pitch;

    assign ctrl          = ucode_rom(pc_reg);
    assign s_axis_tready = ctrl.wait_in;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign top_bit       = word_reg[WORD_W-1];
    assign stall         = out_busy && (((ctrl.op == OP_SHIFT) && top_bit)
                                        || (ctrl.op == OP_STATUS));
    assign advance       = ctrl.wait_in ? in_fire : !stall;

    assign level_eff  = (level_reg == LEVEL_W'(4)) ? '0 : level_reg;
    assign dot_y_raw  = base_y_reg + COORD_W'(row_reg) * COORD_W'(pitch_reg)
                        + {{(COORD_W-OFFSET_W){sub_off_reg[OFFSET_W-1]}}, sub_off_reg};
    assign space_step = COORD_W'({pitch_reg, 2'b00}) + COORD_W'(pitch_reg)
                        + (auto_reg ? COORD_W'(gap_reg) : '0);
    assign two_pitch  = {1'b0, pitch_reg, 1'b0};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_kind_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, out_cp_reg, out_by_reg,
                            out_bx_reg, out_lv_reg, out_dy_reg, out_dx_reg};

    always_comb
    begin
        pc_next       = pc_reg;
        size_next     = size_reg;
        pitch_next    = pitch_reg;
        gap_next      = gap_reg;
        auto_next     = auto_reg;
        sub_off_next  = sub_off_reg;
        pen_x_next    = pen_x_reg;
        base_y_next   = base_y_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        level_next    = level_reg;
        finished_next = finished_reg;
        is_load_next  = is_load_reg;
        bits_next     = bits_reg;
        word_next     = word_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        bright_next   = bright_reg;
        cmpl_next     = cmpl_reg;
        out_kind_next = out_kind_reg;
        out_dx_next   = out_dx_reg;
        out_dy_next   = out_dy_reg;
        out_lv_next   = out_lv_reg;
        out_bx_next   = out_bx_reg;
        out_by_next   = out_by_reg;
        out_cp_next   = out_cp_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (advance)
        begin
            unique case (ctrl.op)
                OP_NONE:
                begin
                    word_next    = s_axis_tdata[WORD_W-1:0];
                    bx_next      = s_axis_tdata[WORD_W +: COORD_W];
                    by_next      = s_axis_tdata[WORD_W+COORD_W +: COORD_W];
                    bright_next  = s_axis_tdata[WORD_W+2*COORD_W +: LEVEL_W];
                    cmpl_next    = s_axis_tdata[WORD_W+2*COORD_W+LEVEL_W];
                    is_load_next = (s_axis_tuser == ACT_LOAD_LEFT)
                                   || (s_axis_tuser == ACT_LOAD_RIGHT);
                end
                OP_SET_SIZE:
                begin
                    size_next    = word_reg[SIZE_W-1:0];
                    pitch_next   = PITCH_W'(2) + PITCH_W'(word_reg[SIZE_W-1:0]);
                    gap_next     = PITCH_W'(4) + PITCH_W'(word_reg[SIZE_W-1:0]);
                    auto_next    = word_reg[SIZE_W];
                    sub_off_next = '0;
                    level_next   = bright_reg;
                end
                OP_SPACE:
                begin
                    bx_next = bx_reg + space_step;
                end
                OP_LOAD_L:
                begin
                    sub_off_next  = word_reg[0] ? OFFSET_W'(0) - OFFSET_W'(two_pitch) : '0;
                    pen_x_next    = bx_reg;
                    base_y_next   = by_reg;
                    level_next    = bright_reg;
                    col_next      = '0;
                    row_next      = '0;
                    finished_next = 1'b0;
                    bits_next     = COUNT_W'(LEFT_BITS);
                end
                OP_LOAD_R:
                begin
                    bits_next = COUNT_W'(RIGHT_BITS);
                end
                OP_SHIFT:
                begin
                    word_next = {word_reg[WORD_W-2:0], 1'b0};
                    bits_next = bits_reg - COUNT_W'(1);
                    if (top_bit)
                    begin
                        level_next     = level_eff;
                        out_valid_next = 1'b1;
                        out_kind_next  = 1'b0;
                        out_dx_next    = screen_coord(pen_x_reg);
                        out_dy_next    = screen_coord(dot_y_raw);
                        out_lv_next    = level_eff + LEVEL_W'(4);
                        out_bx_next    = '0;
                        out_by_next    = '0;
                        out_cp_next    = 1'b0;
                    end
                    if (row_reg == ROW_W'(ROWS - 1))
                    begin
                        row_next   = '0;
                        pen_x_next = pen_x_reg + COORD_W'(pitch_reg);
                        if (col_reg != COL_W'(COLUMNS))
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                OP_CHAR_END:
                begin
                    if (col_reg == COL_W'(COLUMNS))
                    begin
                        finished_next = 1'b1;
                        if (auto_reg)
                        begin
                            pen_x_next = pen_x_reg + COORD_W'(gap_reg);
                        end
                    end
                end
                OP_STATUS:
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b1;
                    out_dx_next    = '0;
                    out_dy_next    = '0;
                    out_lv_next    = '0;
                    out_bx_next    = (is_load_reg && finished_reg) ? pen_x_reg : bx_reg;
                    out_by_next    = (is_load_reg && finished_reg) ? base_y_reg : by_reg;
                    out_cp_next    = cmpl_reg;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !m_axis_tready;
                end
            endcase

            unique case (ctrl.jump)
                JMP_DISPATCH: pc_next = dispatch(s_axis_tuser);
                JMP_GOTO:     pc_next = ctrl.target;
                JMP_LOOP:     pc_next = (bits_reg == COUNT_W'(1))
                                        ? step_t'(pc_reg + 3'd1) : ctrl.target;
                default:      pc_next = STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            size_reg      <= '0;
            pitch_reg     <= '0;
            gap_reg       <= '0;
            auto_reg      <= 1'b0;
            sub_off_reg   <= '0;
            pen_x_reg     <= '0;
            base_y_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            level_reg     <= '0;
            finished_reg  <= 1'b0;
            is_load_reg   <= 1'b0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            size_reg      <= size_next;
            pitch_reg     <= pitch_next;
            gap_reg       <= gap_next;
            auto_reg      <= auto_next;
            sub_off_reg   <= sub_off_next;
            pen_x_reg     <= pen_x_next;
            base_y_reg    <= base_y_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            level_reg     <= level_next;
            finished_reg  <= finished_next;
            is_load_reg   <= is_load_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        bright_reg   <= bright_next;
        cmpl_reg     <= cmpl_next;
        out_kind_reg <= out_kind_next;
        out_dx_reg   <= out_dx_next;
        out_dy_reg   <= out_dy_next;
        out_lv_reg   <= out_lv_next;
        out_bx_reg   <= out_bx_next;
        out_by_reg   <= out_by_next;
        out_cp_reg   <= out_cp_next;
    end

endmodule

/* design/vcdg_checker.sv */
`include "vector_character_dot_generator_assert.svh"

module vcdg_checker
    import vcdg_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    // io_word, beam_x, beam_y, brightness_in, wants_completion, zero fill
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input logic [ACTION_W-1:0]    s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    // dot_x, dot_y, dot_level, beam_x_out, beam_y_out, complete, zero fill
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    localparam int DOT_W = 2 * COORD_W + LEVEL_W;

    // stalled beat holds
    `VCDG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "stalled output beat changed")

    // only the status beat closes a command
    `VCDG_ASSERT_NOW(a_last_is_status, m_axis_tvalid, m_axis_tlast == m_axis_tuser,
        "tlast does not match status kind")

    // dot beats carry no beam or completion
    `VCDG_ASSERT_NOW(a_dot_clean, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[OUT_TDATA_W-1:DOT_W] == '0, "dot beat carries status fields")

    // status beats carry no dot
    `VCDG_ASSERT_NOW(a_status_clean, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[DOT_W-1:0] == '0, "status beat carries dot fields")

    // a command is worked on before the next one is taken
    `VCDG_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input taken on back to back cycles")

endmodule

bind vector_character_dot_generator vcdg_checker u_vcdg_checker (.*);

/* verif/vector_character_dot_generator_tb.sv */
`timescale 1ns / 1ps

module vector_character_dot_generator_tb;
    import vcdg_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam logic                KIND_DOT        = 1'b0;
    localparam logic                KIND_STATUS     = 1'b1;
    localparam int                  CYCLE_LIMIT     = 300000;
    localparam int                  SETTLE_CYCLES   = 40;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [WORD_W-1:0]   word;
        logic [COORD_W-1:0]  bx;
        logic [COORD_W-1:0]  by;
        logic [LEVEL_W-1:0]  bright;
        logic                wc;
    } command_t;

    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [LEVEL_W-1:0] lv;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic               cp;
        logic               last;
    } plot_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ACTION_W-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    command_t     command_q[$];
    plot_result_t plot_q[$];
    logic         beat_in = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           errors = 0;
    int           cycles = 0;
    string        field_name[8] = '{"result_kind", "dot_x", "dot_y", "dot_level",
                                    "beam_x_out", "beam_y_out", "complete", "last"};

    // predictor state
    int size_sel, pitch, gap, auto_adv, sub_off;
    int pen_x, base_y, col_cnt, row_cnt, cur_level, char_done;

    vector_character_dot_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic logic [COORD_W-1:0] to_screen(input int v);
        int c;
        c = v & 1023;
        if (c >= 512)
            c = (c + 1) & 1023;
        return COORD_W'((c + 512) & 1023);
    endfunction

    task automatic plot_matrix(input logic [WORD_W-1:0] w, input int nbits);
        int           off;
        plot_result_t r;
        off = (sub_off >= 16) ? sub_off - 32 : sub_off;
        for (int i = 0; i < nbits; i++)
        begin
            if (w[WORD_W-1])
            begin
                if (cur_level == 4)
                    cur_level = 0;
                r = '{KIND_DOT, to_screen(pen_x),
                      to_screen(base_y + row_cnt * pitch + off),
                      LEVEL_W'((cur_level + 4) & 7), '0, '0, 1'b0, 1'b0};
                plot_q.push_back(r);
            end
            w = w << 1;
            row_cnt++;
            if (row_cnt >= ROWS_DEF)
            begin
                row_cnt = 0;
                if (col_cnt < COLUMNS_DEF)
                    col_cnt++;
                pen_x = (pen_x + pitch) & 1023;
            end
        end
        if (col_cnt >= COLUMNS_DEF)
        begin
            char_done = 1;
            if (auto_adv != 0)
                pen_x = (pen_x + gap) & 1023;
        end
    endtask

    task automatic predict_command(input command_t c);
        int           bx;
        int           by;
        plot_result_t r;
        bx = c.bx;
        by = c.by;
        case (c.action)
            ACT_SET_SIZE:
            begin
                size_sel  = c.word[1:0];
                pitch     = 2 + size_sel;
                gap       = 4 + size_sel;
                auto_adv  = c.word[2];
                sub_off   = 0;
                cur_level = c.bright;
            end
            ACT_SPACE:
                bx = (bx + 5 * pitch + ((auto_adv != 0) ? gap : 0)) & 1023;
            ACT_LOAD_LEFT:
            begin
                sub_off   = c.word[0] ? ((0 - 2 * pitch) & 31) : 0;
                pen_x     = c.bx;
                base_y    = c.by;
                cur_level = c.bright;
                col_cnt   = 0;
                row_cnt   = 0;
                char_done = 0;
                plot_matrix(c.word, LEFT_BITS);
            end
            ACT_LOAD_RIGHT:
                plot_matrix(c.word, RIGHT_BITS);
            default:
            begin
            end
        endcase
        if ((c.action == ACT_LOAD_LEFT || c.action == ACT_LOAD_RIGHT) && char_done != 0)
        begin
            bx = pen_x;
            by = base_y;
        end
        r = '{KIND_STATUS, '0, '0, '0, COORD_W'(bx), COORD_W'(by), c.wc, 1'b1};
        plot_q.push_back(r);
    endtask

    task automatic add_command(input logic [ACTION_W-1:0] action, input int word,
                               input int bx, input int by, input int bright, input int wc);
        command_t c;
        c = '{action, WORD_W'(word), COORD_W'(bx), COORD_W'(by), LEVEL_W'(bright), 1'(wc)};
        command_q.push_back(c);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 511;
            2: return 512;
            3: return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int pick_bright();
        return ($urandom_range(0, 3) == 0) ? 4 : $urandom_range(0, 7);
    endfunction

    task automatic add_random(input int n);
        int count;
        int pick;
        count = 0;
        while (count < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                add_command(ACT_SET_SIZE, $urandom_range(0, 262143), pick_coord(),
                            pick_coord(), pick_bright(), $urandom_range(0, 1));
                count++;
            end
            else if (pick < 62)
            begin
                // well formed character: left half then right half
                add_command(ACT_LOAD_LEFT, $urandom_range(0, 262143), pick_coord(),
                            pick_coord(), pick_bright(), $urandom_range(0, 1));
                add_command(ACT_LOAD_RIGHT, $urandom_range(0, 262143), pick_coord(),
                            pick_coord(), pick_bright(), $urandom_range(0, 1));
                count += 2;
            end
            else if (pick < 76)
            begin
                add_command(ACT_SPACE, $urandom_range(0, 262143), pick_coord(),
                            pick_coord(), pick_bright(), $urandom_range(0, 1));
                count++;
            end
            else if (pick < 83)
            begin
                add_command(ACT_CLEAR_PEN, $urandom_range(0, 262143), pick_coord(),
                            pick_coord(), pick_bright(), $urandom_range(0, 1));
                count++;
            end
            else if (pick < 92)
            begin
                add_command(ACT_LOAD_RIGHT, $urandom_range(0, 262143), pick_coord(),
                            pick_coord(), pick_bright(), $urandom_range(0, 1));
                count++;
            end
            else
            begin
                add_command(ACTION_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
                            $urandom_range(0, 262143), pick_coord(), pick_coord(),
                            pick_bright(), $urandom_range(0, 1));
                count++;
            end
        end
    endtask

    task automatic add_directed();
        // right half with nothing loaded, pitch still zero
        add_command(ACT_LOAD_RIGHT, 18'h3FFFF, 0, 0, 0, 1);
        add_command(ACT_CLEAR_PEN, 18'h3FFFF, 1023, 1023, 7, 1);
        add_command(ACT_SPARE_FIRST, 0, 5, 6, 1, 0);
        add_command(ACT_SPARE_FIRST + 3'd1, 18'h3FFFF, 1023, 0, 7, 1);
        add_command(ACT_SPARE_LAST, 0, 0, 1023, 0, 0);
        add_command(ACT_SET_SIZE, 0, 0, 0, 3, 0);
        add_command(ACT_SPACE, 0, 1023, 1023, 0, 0);
        add_command(ACT_SET_SIZE, 18'h3FFFF, 0, 0, 4, 1);
        add_command(ACT_SPACE, 0, 1020, 512, 0, 1);
        // subscript, intensity 4, beam at the far corner
        add_command(ACT_LOAD_LEFT, 18'h3FFFF, 1023, 1023, 4, 1);
        add_command(ACT_LOAD_RIGHT, 18'h3FFFF, 0, 0, 0, 0);
        add_command(ACT_LOAD_RIGHT, 18'h3FFFF, 0, 0, 0, 1);
        add_command(ACT_LOAD_LEFT, 0, 511, 512, 7, 0);
        add_command(ACT_LOAD_RIGHT, 0, 0, 0, 7, 1);
        add_command(ACT_SET_SIZE, 1, 0, 0, 0, 1);
        add_command(ACT_LOAD_LEFT, 18'h3FFFE, 512, 511, 7, 0);
        add_command(ACT_LOAD_RIGHT, 18'h2AAAA, 0, 1023, 0, 1);
        add_command(ACT_SET_SIZE, 6, 0, 0, 5, 0);
        add_command(ACT_SPACE, 0, 0, 0, 0, 1);
        add_command(ACT_LOAD_LEFT, 18'h15555, 300, 700, 2, 1);
        add_command(ACT_LOAD_RIGHT, 18'h15555, 1, 2, 3, 0);
        add_command(ACT_CLEAR_PEN, 0, 0, 0, 0, 0);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (command_q.size() != 0 || s_axis_tvalid || plot_q.size() != 0);
    endtask

    always @(negedge clk)
    begin : drive
        command_t c;
        if (rst_n)
        begin
            if (beat_in || !s_axis_tvalid)
            begin
                if (command_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    c = command_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, c.wc, c.bright, c.by, c.bx, c.word};
                    s_axis_tuser  <= c.action;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watch
        command_t     c;
        plot_result_t want;
        int           want_f[8];
        int           got_f[8];
        beat_in <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            c = '{s_axis_tuser, s_axis_tdata[17:0], s_axis_tdata[27:18],
                  s_axis_tdata[37:28], s_axis_tdata[40:38], s_axis_tdata[41]};
            predict_command(c);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (plot_q.size() == 0)
            begin
                $display("%0t unexpected beat: tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = plot_q.pop_front();
                want_f = '{want.kind, want.dx, want.dy, want.lv, want.bx, want.by,
                           want.cp, want.last};
                got_f  = '{m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[19:10],
                           m_axis_tdata[22:20], m_axis_tdata[32:23], m_axis_tdata[42:33],
                           m_axis_tdata[43], m_axis_tlast};
                for (int i = 0; i < 8; i++)
                begin
                    if (want_f[i] != got_f[i])
                    begin
                        $display("%0t %s mismatch: expected %0d actual %0d",
                                 $time, field_name[i], want_f[i], got_f[i]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vector_character_dot_generator_tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 50, 0, 12};
        stall_tab = '{0, 0, 50, 12};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            if (p == 0)
                add_directed();
            add_random(20);
            // sender holds off until every result of the phase is back
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (plot_q.size() != 0)
            $display("%0t %0d results never arrived", $time, plot_q.size());
        if (errors == 0 && plot_q.size() == 0)
            $display("vector_character_dot_generator_tb: PASS");
        else
            $display("vector_character_dot_generator_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/vcdg_pkg.sv
design/vector_character_dot_generator.sv
design/vcdg_checker.sv
verif/vector_character_dot_generator_tb.sv
